// ===== hw/rtl/tll_pkg.sv =====
// ----------------------------------------------------------------------------
// tll_pkg
// Shared types and constants of the tree leaf level-order lister.
// ----------------------------------------------------------------------------
package tll_pkg;

   // default node store depth
   localparam int MAX_NODES_DEF = 16;

   // leaf result buffer
   localparam int MAX_RESULTS = 16;
   localparam int RES_AW      = $clog2(MAX_RESULTS);
   localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

   // width of a node index field
   localparam int NODE_W = 4;

   // opcodes
   localparam logic OP_NODE   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_LEAF  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef struct packed {
      logic              opcode;
      logic              left_present;
      logic [NODE_W-1:0] left_child;
      logic              right_present;
      logic [NODE_W-1:0] right_child;
   } tll_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] leaf_index;
      logic [1:0]        status;
      logic              last;
   } tll_rsp_type;

   // control from the walk sequencer to the result buffer
   typedef struct packed {
      logic              leaf_we;
      logic [RES_AW-1:0] leaf_wa;
      logic [NODE_W-1:0] leaf_wd;
      logic [RES_AW-1:0] leaf_ra;
      logic              emit_leaf;
      logic              emit_status;
      logic [1:0]        status;
      logic              last;
   } tll_buf_ctl_type;

endpackage

// ===== hw/rtl/tree_leaf_level_order_lister_top.sv =====
// ----------------------------------------------------------------------------
// tree_leaf_level_order_lister_top
// Loads a binary tree node by node and lists its leaves in level order.
// ----------------------------------------------------------------------------
// A node entry is stored in the child table memory while there is room.
// A finish transaction first scans the table, one entry a cycle, for child
// indices out of range and for the lowest unreferenced node, then walks the
// tree breadth first through a queue memory: each visited node passes
// through a queue read, a table read and a processing step, plus a further
// step to queue its right child when it has one, since the queue memory
// takes one write a cycle. Leaves are then read out of the leaf buffer in
// order, waiting whenever the result side stalls. Empty and malformed trees
// give a single status transaction. No new transaction is taken while a
// finish is in progress; after the last result is loaded the block takes the
// next tree at once, even while that result is still waiting to be taken.
module tree_leaf_level_order_lister_top
   import tll_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tll_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tll_rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int XW = (AW > NODE_W) ? AW : NODE_W;
   localparam int EW = 2 * (NODE_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_QRD,
      ST_TRD,
      ST_PROC,
      ST_RIGHT,
      ST_EMIT,
      ST_EMIT_WAIT,
      ST_STATUS
   } state_type;

   // child table: {left present, left, right present, right}
   logic [EW-1:0]     tbl_mem [MAX_NODES];
   logic [EW-1:0]     tbl_rd_ff;
   logic              tbl_we;
   logic [AW-1:0]     tbl_wa;
   logic [EW-1:0]     tbl_wd;
   logic [AW-1:0]     tbl_ra;

   // walk queue
   logic [NODE_W-1:0] q_mem [MAX_NODES];
   logic [NODE_W-1:0] q_rd_ff;
   logic              q_we;
   logic [AW-1:0]     q_wa;
   logic [NODE_W-1:0] q_wd;
   logic [AW-1:0]     q_ra;

   state_type         state_ff, state_in;
   logic [MAX_NODES-1:0] marks_ff, marks_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic              bad_ff, bad_in;
   logic              root_found_ff, root_found_in;
   logic [AW-1:0]     root_ff, root_in;
   logic [CW-1:0]     head_ff, head_in;
   logic [CW-1:0]     tail_ff, tail_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W:0]   right_ff, right_in;
   logic [RES_CW-1:0] leaves_ff, leaves_in;
   logic [RES_CW-1:0] emit_ff, emit_in;
   logic [1:0]        status_ff, status_in;

   tll_buf_ctl_type   ctl;
   logic              rsp_free;

   logic [XW-1:0]     lx;
   logic [XW-1:0]     rx;
   logic              lp, rp;
   logic [NODE_W-1:0] lc, rc;

   // memories, registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= tbl_mem[tbl_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wa] <= q_wd;
      end
      q_rd_ff <= q_mem[q_ra];
   end

   // unpack table read data
   assign lp = tbl_rd_ff[EW-1];
   assign lc = tbl_rd_ff[EW-2 -: NODE_W];
   assign rp = tbl_rd_ff[NODE_W];
   assign rc = tbl_rd_ff[NODE_W-1:0];

   // mark indices widened to the store address
   assign lx = XW'(req_data.left_child);
   assign rx = XW'(req_data.right_child);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      marks_in      = marks_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      bad_in        = bad_ff;
      root_found_in = root_found_ff;
      root_in       = root_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      node_in       = node_ff;
      right_in      = right_ff;
      leaves_in     = leaves_ff;
      emit_in       = emit_ff;
      status_in     = status_ff;

      req_ready = 1'b0;
      tbl_we    = 1'b0;
      tbl_wa    = count_ff[AW-1:0];
      tbl_wd    = {req_data.left_present,
                   req_data.left_present ? req_data.left_child : NODE_W'(0),
                   req_data.right_present,
                   req_data.right_present ? req_data.right_child : NODE_W'(0)};
      tbl_ra    = scan_ff[AW-1:0];
      q_we      = 1'b0;
      q_wa      = tail_ff[AW-1:0];
      q_wd      = lc;
      q_ra      = head_ff[AW-1:0];
      ctl       = '0;
      ctl.leaf_wa = leaves_ff[RES_AW-1:0];
      ctl.leaf_wd = node_ff;
      ctl.leaf_ra = emit_ff[RES_AW-1:0];
      ctl.status  = status_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.opcode == OP_NODE) begin
                  // store entry and mark its children
                  if (32'(count_ff) < MAX_NODES) begin
                     tbl_we   = 1'b1;
                     count_in = CW'(count_ff + CW'(1));
                     if (req_data.left_present && (32'(req_data.left_child) < MAX_NODES)) begin
                        marks_in[lx[AW-1:0]] = 1'b1;
                     end
                     if (req_data.right_present &&
                         (32'(req_data.right_child) < MAX_NODES)) begin
                        marks_in[rx[AW-1:0]] = 1'b1;
                     end
                  end
               end else if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_STATUS;
               end else begin
                  scan_in       = '0;
                  pend_in       = 1'b0;
                  bad_in        = 1'b0;
                  root_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue table read and look for the root
            if (scan_ff < count_ff) begin
               if (!root_found_ff && !marks_ff[scan_ff[AW-1:0]]) begin
                  root_found_in = 1'b1;
                  root_in       = scan_ff[AW-1:0];
               end
               scan_in = CW'(scan_ff + CW'(1));
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // range check of the entry read last cycle
            if (pend_ff) begin
               if ((lp && !(32'(lc) < 32'(count_ff))) ||
                   (rp && !(32'(rc) < 32'(count_ff)))) begin
                  bad_in = 1'b1;
               end
            end
            if ((scan_ff == count_ff) && !pend_ff) begin
               if (bad_ff || !root_found_ff) begin
                  status_in = STATUS_BAD;
                  state_in  = ST_STATUS;
               end else begin
                  q_we      = 1'b1;
                  q_wa      = '0;
                  q_wd      = NODE_W'(root_ff);
                  head_in   = '0;
                  tail_in   = CW'(1);
                  leaves_in = '0;
                  state_in  = ST_QRD;
               end
            end
         end

         ST_QRD: begin
            if (head_ff < tail_ff) begin
               head_in  = CW'(head_ff + CW'(1));
               state_in = ST_TRD;
            end else if (leaves_ff == '0) begin
               marks_in = '0;
               count_in = '0;
               head_in  = '0;
               tail_in  = '0;
               state_in = ST_IDLE;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end

         ST_TRD: begin
            node_in  = q_rd_ff;
            tbl_ra   = AW'(q_rd_ff);
            state_in = ST_PROC;
         end

         ST_PROC: begin
            right_in = {rp, rc};
            if (!lp && !rp) begin
               // leaf: keep it in the result buffer
               if (32'(leaves_ff) >= MAX_RESULTS) begin
                  status_in = STATUS_BAD;
                  state_in  = ST_STATUS;
               end else begin
                  ctl.leaf_we = 1'b1;
                  leaves_in   = RES_CW'(leaves_ff + RES_CW'(1));
                  state_in    = ST_QRD;
               end
            end else if (lp) begin
               if (tail_ff >= count_ff) begin
                  status_in = STATUS_BAD;
                  state_in  = ST_STATUS;
               end else begin
                  q_we     = 1'b1;
                  q_wd     = lc;
                  tail_in  = CW'(tail_ff + CW'(1));
                  state_in = rp ? ST_RIGHT : ST_QRD;
               end
            end else begin
               state_in = ST_RIGHT;
            end
         end

         ST_RIGHT: begin
            if (tail_ff >= count_ff) begin
               status_in = STATUS_BAD;
               state_in  = ST_STATUS;
            end else begin
               q_we     = 1'b1;
               q_wd     = right_ff[NODE_W-1:0];
               tail_in  = CW'(tail_ff + CW'(1));
               state_in = ST_QRD;
            end
         end

         ST_EMIT: begin
            // wait until the output slot frees up; the leaf memory reads the current index
            if (rsp_free) begin
               state_in = ST_EMIT_WAIT;
            end
         end

         ST_EMIT_WAIT: begin
            ctl.emit_leaf = 1'b1;
            ctl.last      = (RES_CW'(emit_ff + RES_CW'(1)) == leaves_ff);
            emit_in       = RES_CW'(emit_ff + RES_CW'(1));
            if (ctl.last) begin
               marks_in = '0;
               count_in = '0;
               head_in  = '0;
               tail_in  = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_STATUS: begin
            if (rsp_free) begin
               ctl.emit_status = 1'b1;
               ctl.last        = 1'b1;
               marks_in        = '0;
               count_in        = '0;
               head_in         = '0;
               tail_in         = '0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         marks_ff      <= '0;
         count_ff      <= '0;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         bad_ff        <= 1'b0;
         root_found_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         leaves_ff     <= '0;
         emit_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         marks_ff      <= marks_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         pend_ff       <= pend_in;
         bad_ff        <= bad_in;
         root_found_ff <= root_found_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         leaves_ff     <= leaves_in;
         emit_ff       <= emit_in;
      end
      root_ff   <= root_in;
      node_ff   <= node_in;
      right_ff  <= right_in;
      status_ff <= status_in;
   end

   // leaf buffer and output register
   tll_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rsp_free  (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/tll_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// tll_rsp_buf
// Leaf buffer memory and result output register. Leaves found by the walk are
// held here until the walk is known to be well formed, then read out in order.
// ----------------------------------------------------------------------------
module tll_rsp_buf
   import tll_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  tll_buf_ctl_type ctl,
   output logic            rsp_free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output tll_rsp_type     rsp_data
);

   logic [NODE_W-1:0] leaf_mem [MAX_RESULTS];
   logic [NODE_W-1:0] leaf_rd_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   tll_rsp_type rsp_data_ff;
   tll_rsp_type rsp_data_in;

   // leaf memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.leaf_we) begin
         leaf_mem[ctl.leaf_wa] <= ctl.leaf_wd;
      end
      leaf_rd_ff <= leaf_mem[ctl.leaf_ra];
   end

   // output slot is free when empty or being taken now
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit_leaf) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.leaf_index = leaf_rd_ff;
         rsp_data_in.status     = STATUS_LEAF;
         rsp_data_in.last       = ctl.last;
      end else if (ctl.emit_status) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.leaf_index = '0;
         rsp_data_in.status     = ctl.status;
         rsp_data_in.last       = ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
